// ===== sv/red_black_heat_plate_solver_top_defines.svh =====
// Assertion macros shared by the heat plate solver RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef RED_BLACK_HEAT_PLATE_SOLVER_TOP_DEFINES_SVH
`define RED_BLACK_HEAT_PLATE_SOLVER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RBHP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbhp check failed");
`define RBHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbhp check failed");
`else
`define RBHP_ASSERT_SAME(label, ante, cons)
`define RBHP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/rbhp_pkg.sv =====
// Shared constants, codes and control structs for the heat plate solver.
// No dependencies.
package rbhp_pkg;
  localparam int DEF_GRID_ROWS = 64;
  localparam int DEF_GRID_COLS = 64;
  localparam int DEF_FRAC_BITS = 16;
  localparam int FIELD_W = 23;
  localparam int CNT_W = 16;
  localparam int POS_W = 6;
  localparam logic [FIELD_W-1:0] TOL_RESET = 23'd66;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 16'hFFFF;
  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_SWEEP_LIMIT = 1'b1;
  localparam logic FUNC_SOLVE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic             go;
    logic             is_read;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic               done;
    logic [FIELD_W-1:0] value;
    logic [CNT_W-1:0]   sweeps;
    logic [FIELD_W-1:0] change;
    logic               limit;
  } res_t;
endpackage

// ===== sv/rbhp_grid_ram.sv =====
// Grid memory: one write port and one registered read port.
// Depends on nothing but its parameters.
module rbhp_grid_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 23
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== sv/rbhp_sweep_ctrl.sv =====
// Sequencer that builds the grid, runs red-black sweeps and serves cell reads.
// Depends on rbhp_pkg, rbhp_grid_ram and the assertion macro header.
`include "red_black_heat_plate_solver_top_defines.svh"
module rbhp_sweep_ctrl #(
  parameter int GRID_ROWS = rbhp_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = rbhp_pkg::DEF_GRID_COLS,
  parameter int FRAC_BITS = rbhp_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rbhp_pkg::cmd_t               cmd,
  input  logic [rbhp_pkg::FIELD_W-1:0] tolerance,
  input  logic [rbhp_pkg::CNT_W-1:0]   sweep_limit,
  output logic                         idle,
  output rbhp_pkg::res_t               res
);
  import rbhp_pkg::*;

  localparam int VW = FRAC_BITS + 7;
  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW = $clog2(CELLS);
  localparam int RW = $clog2(GRID_ROWS);
  localparam int CW = $clog2(GRID_COLS);
  localparam longint unsigned HOT_L = 64'd100 << FRAC_BITS;
  localparam longint unsigned MEAN_L =
    (HOT_L * (2 * GRID_ROWS + GRID_COLS - 4)) / (2 * GRID_ROWS + 2 * GRID_COLS - 4);
  localparam logic [VW-1:0] HOT_VAL = HOT_L[VW-1:0];
  localparam logic [VW-1:0] MEAN_VAL = MEAN_L[VW-1:0];

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_CELL = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;

  logic [2:0]      st;
  logic [2:0]      step;
  logic [RW-1:0]   r;
  logic [CW-1:0]   c;
  logic            par;
  logic [VW+1:0]   sum;
  logic [VW-1:0]   worst;
  logic [CNT_W-1:0] cnt;
  logic            solved;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [VW-1:0]   wr_data;
  logic [AW-1:0]   rd_addr;
  logic [VW-1:0]   rd_data;
  logic [AW-1:0]   at;
  logic [VW-1:0]   init_val;
  logic [VW-1:0]   nw;
  logic [VW-1:0]   diff;
  logic [VW-1:0]   worst_now;
  logic [CNT_W-1:0] cnt_next;
  logic            in_range;
  logic            keep_going;

  rbhp_grid_ram #(.DEPTH(CELLS), .WIDTH(VW)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  function automatic logic [CW-1:0] first_col(input logic rb, input logic p);
    first_col = (rb ^ p) ? CW'(1) : CW'(2);
  endfunction

  always_comb begin
    at = AW'(32'(r) * GRID_COLS + 32'(c));
    if (r == '0) begin
      init_val = '0;
    end else if (32'(r) == GRID_ROWS - 1 || c == '0 || 32'(c) == GRID_COLS - 1) begin
      init_val = HOT_VAL;
    end else begin
      init_val = MEAN_VAL;
    end
    nw = sum[VW+1:2];
    diff = (nw > rd_data) ? (nw - rd_data) : (rd_data - nw);
    worst_now = (diff > worst) ? diff : worst;
    cnt_next = cnt + CNT_W'(1);
    keep_going = (32'(worst_now) >= 32'(tolerance)) && (cnt_next < sweep_limit);
    in_range = (32'(cmd.row) < GRID_ROWS) && (32'(cmd.col) < GRID_COLS);
    wr_en = (st == ST_INIT) || (st == ST_CELL && step == 3'd5);
    wr_addr = at;
    wr_data = (st == ST_INIT) ? init_val : nw;
    case (step)
      3'd0:    rd_addr = at - AW'(GRID_COLS);
      3'd1:    rd_addr = at + AW'(GRID_COLS);
      3'd2:    rd_addr = at - AW'(1);
      3'd3:    rd_addr = at + AW'(1);
      default: rd_addr = at;
    endcase
    if (st == ST_IDLE) begin
      rd_addr = AW'(32'(cmd.row) * GRID_COLS + 32'(cmd.col));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      res.done <= 1'b0;
      res.sweeps <= '0;
      res.change <= '0;
      res.limit <= 1'b0;
      res.value <= '0;
      solved <= 1'b0;
    end else begin
      res.done <= 1'b0;
      unique case (st)
        ST_IDLE: begin
          if (cmd.go) begin
            if (cmd.is_read == FUNC_READ) begin
              if (solved && in_range) begin
                st <= ST_READ;
              end else begin
                res.value <= '0;
                res.done <= 1'b1;
              end
            end else begin
              r <= '0;
              c <= '0;
              st <= ST_INIT;
            end
          end
        end
        ST_READ: begin
          res.value <= FIELD_W'(rd_data);
          res.done <= 1'b1;
          st <= ST_IDLE;
        end
        ST_INIT: begin
          if (32'(c) == GRID_COLS - 1) begin
            c <= '0;
            if (32'(r) == GRID_ROWS - 1) begin
              r <= RW'(1);
              c <= first_col(1'b1, 1'b0);
              par <= 1'b0;
              step <= '0;
              worst <= '0;
              cnt <= '0;
              st <= ST_CELL;
            end else begin
              r <= r + RW'(1);
            end
          end else begin
            c <= c + CW'(1);
          end
        end
        ST_CELL: begin
          step <= step + 3'd1;
          if (step == 3'd1) begin
            sum <= (VW+2)'(rd_data);
          end else if (step == 3'd2 || step == 3'd3 || step == 3'd4) begin
            sum <= sum + (VW+2)'(rd_data);
          end
          // The old value of the cell arrives last; write the average and move on.
          if (step == 3'd5) begin
            step <= '0;
            worst <= worst_now;
            if (32'(c) + 2 <= GRID_COLS - 2) begin
              c <= c + CW'(2);
            end else if (32'(r) < GRID_ROWS - 2) begin
              r <= r + RW'(1);
              c <= first_col(~r[0], par);
            end else if (!par) begin
              par <= 1'b1;
              r <= RW'(1);
              c <= first_col(1'b1, 1'b1);
            end else begin
              cnt <= cnt_next;
              r <= RW'(1);
              c <= first_col(1'b1, 1'b0);
              par <= 1'b0;
              if (keep_going) begin
                worst <= '0;
              end else begin
                res.sweeps <= cnt_next;
                res.change <= FIELD_W'(worst_now);
                res.limit <= (32'(worst_now) >= 32'(tolerance));
                res.value <= '0;
                res.done <= 1'b1;
                solved <= 1'b1;
                st <= ST_IDLE;
              end
            end
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  assign idle = (st == ST_IDLE);

  `RBHP_ASSERT_SAME(a_write_only_when_busy, wr_en, st == ST_INIT || st == ST_CELL)
  `RBHP_ASSERT_SAME(a_sweep_rows_interior, st == ST_CELL,
                    r != '0 && 32'(r) <= GRID_ROWS - 2 && c != '0)
  `RBHP_ASSERT_NEXT(a_done_returns_idle, res.done, st == ST_IDLE || st == ST_INIT)
  `RBHP_ASSERT_SAME(a_solved_has_sweeps, solved, res.sweeps != '0)
endmodule

// ===== sv/red_black_heat_plate_solver_top.sv =====
// Heat plate solver top level: configuration registers, item handshakes and
// output register. Depends on rbhp_pkg and rbhp_sweep_ctrl.
//
// Use: an input item with func = 0 rebuilds the plate and solves it by
// red-black sweeps; func = 1 reads the cell at row, col. Each item gives one
// result item. cell_value is zero for a solve and for reads before the first
// solve or outside the grid; the other fields show the last solve.
// Input items are taken when in_valid is high and in_stall low; results leave
// when out_valid is high and out_stall low. The block takes one item at a
// time and holds in_stall high until the previous result has been taken.
// A solve first builds the grid, then in each sweep updates every interior
// cell with five reads on the single memory read port.
// Configuration writes (tolerance at index 0, sweep_limit at index 1) are
// always ready and must only be made while the block is idle.
// Reset restores the register defaults and clears the solve status; the grid
// memory is not cleared. A stalled result simply holds in the output register.
module red_black_heat_plate_solver_top #(
  parameter int GRID_ROWS = rbhp_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = rbhp_pkg::DEF_GRID_COLS,
  parameter int FRAC_BITS = rbhp_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic [rbhp_pkg::POS_W-1:0]   row,
  input  logic [rbhp_pkg::POS_W-1:0]   col,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rbhp_pkg::FIELD_W-1:0] cell_value,
  output logic [rbhp_pkg::CNT_W-1:0]   sweeps_done,
  output logic [rbhp_pkg::FIELD_W-1:0] final_change,
  output logic                         hit_limit,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [rbhp_pkg::FIELD_W-1:0] cfg_data
);
  import rbhp_pkg::*;

  logic [FIELD_W-1:0] tolerance;
  logic [CNT_W-1:0]   sweep_limit;
  cmd_t               cmd;
  res_t               res;
  logic               ctrl_idle;

  assign cfg_ready = 1'b1;
  assign in_stall = !ctrl_idle || res.done || out_valid;
  assign cmd.go = in_valid && !in_stall;
  assign cmd.is_read = func;
  assign cmd.row = row;
  assign cmd.col = col;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      sweep_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TOLERANCE:   tolerance <= cfg_data;
        CFG_SWEEP_LIMIT: sweep_limit <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  rbhp_sweep_ctrl #(
    .GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS), .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk(clk), .rst(rst), .cmd(cmd), .tolerance(tolerance),
    .sweep_limit(sweep_limit), .idle(ctrl_idle), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      cell_value <= res.value;
      sweeps_done <= res.sweeps;
      final_change <= res.change;
      hit_limit <= res.limit;
    end
  end
endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the red-black heat plate solver: a queued driver,
// a checking monitor and an in-bench plate solver that predicts every result.
// Depends on rbhp_pkg and red_black_heat_plate_solver_top.
module tb_top;
  import rbhp_pkg::*;

  localparam int ROWS = DEF_GRID_ROWS;
  localparam int COLS = DEF_GRID_COLS;
  localparam int HOT = 100 << DEF_FRAC_BITS;
  localparam int WATCH_LIMIT = 400000;

  typedef struct {
    logic             func;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } cmd_item_t;

  typedef struct {
    logic [FIELD_W-1:0] value;
    logic [CNT_W-1:0]   sweeps;
    logic [FIELD_W-1:0] change;
    logic               limit;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = FUNC_READ;
  logic [POS_W-1:0] row = '0;
  logic [POS_W-1:0] col = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FIELD_W-1:0] cell_value;
  logic [CNT_W-1:0] sweeps_done;
  logic [FIELD_W-1:0] final_change;
  logic hit_limit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_TOLERANCE;
  logic [FIELD_W-1:0] cfg_data = '0;

  red_black_heat_plate_solver_top u_top (.*);

  cmd_item_t pending_cmds[$];
  reply_t expected_replies[$];

  // Predicted block state.
  logic [FIELD_W-1:0] plate[ROWS][COLS];
  logic               plate_solved = 1'b0;
  logic [CNT_W-1:0]   last_sweeps = '0;
  logic [FIELD_W-1:0] last_change = '0;
  logic               last_limit = 1'b0;
  logic [FIELD_W-1:0] tolerance_reg = TOL_RESET;
  logic [CNT_W-1:0]   sweep_limit_reg = LIMIT_RESET;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // One colour pass over the interior; returns the running largest change.
  function automatic int unsigned colour_pass(int parity, int unsigned worst);
    int unsigned sum, nv, ov, d;
    for (int r = 1; r < ROWS - 1; r++) begin
      for (int c = 1; c < COLS - 1; c++) begin
        if (((r + c) & 1) == parity) begin
          ov = plate[r][c];
          sum = plate[r-1][c] + plate[r+1][c] + plate[r][c-1] + plate[r][c+1];
          nv = sum >> 2;
          plate[r][c] = nv[FIELD_W-1:0];
          d = (nv > ov) ? nv - ov : ov - nv;
          if (d > worst) worst = d;
        end
      end
    end
    return worst;
  endfunction

  function automatic void solve_plate();
    longint mean_val;
    int unsigned change;
    int unsigned count;
    mean_val = (longint'(HOT) * (2 * ROWS + COLS - 4)) / (2 * ROWS + 2 * COLS - 4);
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (r == 0) plate[r][c] = '0;
        else if (r == ROWS - 1 || c == 0 || c == COLS - 1) plate[r][c] = FIELD_W'(HOT);
        else plate[r][c] = mean_val[FIELD_W-1:0];
      end
    end
    count = 0;
    // At least one sweep runs, even with a zero sweep limit.
    do begin
      change = colour_pass(0, 0);
      change = colour_pass(1, change);
      count++;
    end while (change >= tolerance_reg && count < sweep_limit_reg);
    last_sweeps = count[CNT_W-1:0];
    last_change = change[FIELD_W-1:0];
    last_limit = (change >= tolerance_reg);
    plate_solved = 1'b1;
  endfunction

  function automatic reply_t predict_reply(logic f, logic [POS_W-1:0] r, logic [POS_W-1:0] c);
    reply_t rep;
    rep.value = '0;
    if (f == FUNC_SOLVE) solve_plate();
    else if (plate_solved && r < ROWS && c < COLS) rep.value = plate[r][c];
    rep.sweeps = last_sweeps;
    rep.change = last_change;
    rep.limit = last_limit;
    return rep;
  endfunction

  // Driver: offers queued items, predicts each one as it is accepted.
  always @(posedge clk) begin
    cmd_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_replies.push_back(predict_reply(func, row, col));
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_cmds.pop_front();
          in_valid <= 1'b1;
          func <= nxt.func;
          row <= nxt.row;
          col <= nxt.col;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: drives the result stall and checks every accepted result item.
  always @(posedge clk) begin
    reply_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item: cell %0d", cell_value);
        end else begin
          exp_r = expected_replies.pop_front();
          if (cell_value !== exp_r.value || sweeps_done !== exp_r.sweeps ||
              final_change !== exp_r.change || hit_limit !== exp_r.limit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       exp_r.value, exp_r.sweeps, exp_r.change, exp_r.limit,
                       cell_value, sweeps_done, final_change, hit_limit);
          end
        end
      end
      if (hold_request && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= 300;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog over cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("[red_black_heat_plate_solver_top] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [FIELD_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TOLERANCE) tolerance_reg = data;
    else sweep_limit_reg = data[CNT_W-1:0];
  endtask

  task automatic add_cmd(logic f, int r, int c);
    cmd_item_t it;
    it.func = f;
    it.row = POS_W'(r);
    it.col = POS_W'(c);
    pending_cmds.push_back(it);
  endtask

  // Sampled away from the rising edge so that the driver's updates have settled.
  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() > 0 || in_valid || expected_replies.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_mode(logic [FIELD_W-1:0] tol, logic [CNT_W-1:0] lim);
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_SWEEP_LIMIT, FIELD_W'(lim));
  endtask

  initial begin
    int solves;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reads before any solve must return zero.
    add_cmd(FUNC_READ, 0, 0);
    add_cmd(FUNC_READ, 63, 63);
    add_cmd(FUNC_READ, 21, 42);
    drain();
    // Huge tolerance with the largest limit converges after one sweep.
    set_mode(23'd6553600, 16'hFFFF);
    add_cmd(FUNC_SOLVE, 63, 63);
    add_cmd(FUNC_READ, 0, 0);
    add_cmd(FUNC_READ, 63, 0);
    add_cmd(FUNC_READ, 0, 63);
    add_cmd(FUNC_READ, 1, 1);
    add_cmd(FUNC_READ, 62, 62);
    drain();
    // Zero tolerance never converges and stops at the limit.
    set_mode(23'd0, 16'd2);
    add_cmd(FUNC_SOLVE, 0, 0);
    add_cmd(FUNC_READ, 31, 32);
    add_cmd(FUNC_READ, 63, 63);
    drain();
    // A zero sweep limit still runs one sweep.
    set_mode(23'd0, 16'd0);
    add_cmd(FUNC_SOLVE, 0, 0);
    add_cmd(FUNC_READ, 2, 5);
    drain();
    // Convergence on the limit sweep wins over the limit flag.
    set_mode(23'd6553600, 16'd1);
    add_cmd(FUNC_SOLVE, 10, 10);
    add_cmd(FUNC_READ, 1, 2);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_mode(FIELD_W'($urandom_range(6553600, 1000)), CNT_W'($urandom_range(3, 1)));
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 66 : 27) : 0;
      stall_pct = (ph == 2) ? 66 : ((ph == 3) ? 27 : 0);
      if (ph == 1) hold_request = 1'b1;
      solves = 0;
      for (int i = 0; i < 200; i++) begin
        if (solves < 2 && $urandom_range(99) == 0) begin
          add_cmd(FUNC_SOLVE, $urandom_range(63), $urandom_range(63));
          solves++;
        end else begin
          add_cmd(FUNC_READ, $urandom_range(63), $urandom_range(63));
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("[red_black_heat_plate_solver_top] OK");
    end else begin
      $display("[red_black_heat_plate_solver_top] ERROR");
    end
    $finish;
  end
endmodule

// ===== red_black_heat_plate_solver_top.f =====
+incdir+sv
sv/rbhp_pkg.sv
sv/rbhp_grid_ram.sv
sv/rbhp_sweep_ctrl.sv
sv/red_black_heat_plate_solver_top.sv
bench/tb_top.sv
